### src/fsst_pkg.sv
// Shared types and constants for the first-free slot table.
`timescale 1ns / 1ps
`default_nettype none

package fsst_pkg;

  // Fixed port field widths.
  localparam int OP_W     = 2;
  localparam int IDX_W    = 6;
  localparam int VAL_W    = 32;
  localparam int OCC_W    = 7;
  localparam int STATUS_W = 2;

  // Operation codes carried on the opcode field.
  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_SET   = 2'd1,
    OP_GET   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  // Control states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

`default_nettype wire

### src/first_free_slot_table_unit.sv
// First-free slot table: value memory, occupancy flags and operation control.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+------------------------------
//  command   | opcode, slot_index, entry_value           | taken when start & !busy
//  result    | placed_slot, read_value, occupancy, status| valid for one cycle with done
//
// In each transaction the accept edge issues the memory read, the next edge does the
// read-modify-write and registers the result, and done is high in the cycle after
// that. Busy is high for the one cycle in between, and no new command is taken while
// busy. Reset clears every occupancy flag and the count at once, so no clearing pass
// is needed. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module first_free_slot_table_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [fsst_pkg::OP_W-1:0]        opcode,
  input  wire logic [fsst_pkg::IDX_W-1:0]       slot_index,
  input  wire logic [fsst_pkg::VAL_W-1:0]       entry_value,
  output logic                                  done,
  output logic [fsst_pkg::IDX_W-1:0]            placed_slot,
  output logic [fsst_pkg::VAL_W-1:0]            read_value,
  output logic [fsst_pkg::OCC_W-1:0]            occupancy,
  output logic [fsst_pkg::STATUS_W-1:0]         status
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [12:0] DEPTH_L = 13'(TABLE_DEPTH);

  // Control and captured command.
  fsst_pkg::state_t state, state_next;
  fsst_pkg::op_t    op_q;
  logic [fsst_pkg::IDX_W-1:0] idx_q;
  logic [VALUE_WIDTH-1:0]     val_q;

  // Storage: value memory, occupancy flags and fill count.
  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [TABLE_DEPTH-1:0] valid, valid_next;
  logic [CNT_W-1:0]       count, count_next;

  // Execute-stage signals.
  logic                   accept;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [ADDR_W-1:0]      addr_q;
  logic                   range_bad;
  logic                   free_found;
  logic [ADDR_W-1:0]      free_idx;
  logic [fsst_pkg::IDX_W-1:0]    placed_next;
  logic [fsst_pkg::VAL_W-1:0]    read_next;
  fsst_pkg::status_t             status_next;

  assign accept = start && (state == fsst_pkg::S_IDLE);
  assign busy   = (state == fsst_pkg::S_EXEC);

  // State register and command capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
    if (accept) begin
      op_q  <= fsst_pkg::op_t'(opcode);
      idx_q <= slot_index;
      val_q <= VALUE_WIDTH'(entry_value);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fsst_pkg::S_IDLE: begin
        if (start) state_next = fsst_pkg::S_EXEC;
      end
      fsst_pkg::S_EXEC: begin
        state_next = fsst_pkg::S_IDLE;
      end
      default: state_next = fsst_pkg::S_IDLE;
    endcase
  end

  // Value memory: one write port, written only in the execute cycle, and one
  // registered read port.
  always_ff @(posedge clk) begin
    if (busy && mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= mem[ADDR_W'(slot_index)];
    end
  end

  // Lowest empty slot from the occupancy flags.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = ADDR_W'(i);
      end
    end
  end

  assign addr_q    = ADDR_W'(idx_q);
  assign range_bad = ({7'd0, idx_q} >= DEPTH_L);

  // Execute the captured command against the flags, count and read data.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = val_q;
    valid_next  = valid;
    count_next  = count;
    placed_next = '0;
    read_next   = '0;
    status_next = fsst_pkg::ST_OK;
    case (op_q)
      fsst_pkg::OP_ADD: begin
        if (val_q == '0) begin
          status_next = fsst_pkg::ST_ZERO;
        end else if (!free_found) begin
          status_next = fsst_pkg::ST_FULL;
        end else begin
          mem_we               = 1'b1;
          mem_waddr            = free_idx;
          valid_next[free_idx] = 1'b1;
          count_next           = count + CNT_W'(1);
          placed_next          = fsst_pkg::IDX_W'(free_idx);
        end
      end
      fsst_pkg::OP_SET: begin
        if (range_bad) begin
          status_next = fsst_pkg::ST_RANGE;
        end else begin
          mem_we             = 1'b1;
          valid_next[addr_q] = (val_q != '0);
          if (valid[addr_q] && (val_q == '0)) begin
            count_next = count - CNT_W'(1);
          end else if (!valid[addr_q] && (val_q != '0)) begin
            count_next = count + CNT_W'(1);
          end
        end
      end
      fsst_pkg::OP_GET: begin
        if (range_bad) begin
          status_next = fsst_pkg::ST_RANGE;
        end else if (valid[addr_q]) begin
          read_next = fsst_pkg::VAL_W'(rdata);
        end
      end
      default: begin
        valid_next = '0;
        count_next = '0;
      end
    endcase
  end

  // Flags, count and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy;
      if (busy) begin
        valid <= valid_next;
        count <= count_next;
      end
    end
    if (busy) begin
      placed_slot <= placed_next;
      read_value  <= read_next;
      occupancy   <= fsst_pkg::OCC_W'(count_next);
      status      <= status_next;
    end
  end

`ifndef SYNTH
  // A result follows exactly one execute cycle.
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == fsst_pkg::S_EXEC))
    else $error("result strobe without a preceding execute cycle");

  // Execute lasts a single cycle.
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == fsst_pkg::S_EXEC) |=> (state == fsst_pkg::S_IDLE))
    else $error("execute state held for more than one cycle");

  // The fill count tracks the occupancy flags.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(count))
    else $error("fill count differs from occupancy flags");

  // A successful add lands on a slot that was empty.
  a_add_to_empty: assert property (@(posedge clk) disable iff (rst)
    (busy && (op_q == fsst_pkg::OP_ADD) && mem_we) |-> !valid[mem_waddr])
    else $error("add wrote an occupied slot");
`endif

endmodule

`default_nettype wire
